>>> rtl/stepper_ramp_pulse_rate_assert.svh
// Assertion macros used by the stepper ramp top level.
`ifndef STEPPER_RAMP_PULSE_RATE_ASSERT_SVH
`define STEPPER_RAMP_PULSE_RATE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRPR_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);
`define SRPR_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);
`else
`define SRPR_ASSERT_IMP(lbl, clk, rstn, a, b, msg)
`define SRPR_ASSERT_NXT(lbl, clk, rstn, a, b, msg)
`endif
`endif

>>> rtl/srpr_pkg.sv
// Package with widths, commands, status and helpers of the stepper ramp block.
`default_nettype none
package srpr_pkg;
    localparam int COUNT_W  = 24;
    localparam int RAMP_W   = COUNT_W - 1;
    localparam int PERIOD_W = 16;
    localparam int RATE_W   = 20;
    localparam int DIVD_W   = 40;
    localparam int DIVS_W   = RAMP_W;
    localparam int CNT_W    = 6;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 40;
    localparam int ADDR_W   = 3;

    localparam logic [DIVD_W-1:0]   TICK_HZ      = DIVD_W'(1000000);
    localparam logic [RATE_W-1:0]   RESET_RATE   = RATE_W'(500);
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = PERIOD_W'(1999);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(65535);

    localparam logic OP_START = 1'b0;
    localparam logic OP_PULSE = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CFG_TAKE,
        CMD_CFG_APPLY,
        CMD_LOAD,
        CMD_DISPATCH,
        CMD_START_APPLY,
        CMD_PULSE,
        CMD_LERP_MUL,
        CMD_DIV_LERP,
        CMD_LERP_APPLY,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic cfg_pending;
        logic cruise_zero;
        logic in_valid;
        logic in_start;
        logic start_need_div;
        logic pulse_lerp;
        logic div_done;
        logic out_free;
    } status_t;

    // Period from a quotient of the tick rate: quotient of zero counts as one.
    function automatic logic [PERIOD_W-1:0] period_from_quot(input logic [DIVD_W-1:0] q);
        logic [DIVD_W-1:0] p;
        begin
            p = (q == '0) ? '0 : q - DIVD_W'(1);
            period_from_quot = (p > DIVD_W'(PERIOD_MAX)) ? PERIOD_MAX : p[PERIOD_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/srpr_div.sv
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module srpr_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [srpr_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [srpr_pkg::DIVS_W-1:0]   divisor,
    output logic                               done,
    output logic [srpr_pkg::DIVD_W-1:0]        quotient
);
    import srpr_pkg::*;

    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    // One trial subtraction per cycle.
    always_comb begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                if (diff[DIVS_W]) begin
                    rem_reg <= trial[DIVS_W-1:0];
                end else begin
                    rem_reg <= diff[DIVS_W-1:0];
                end
                quo_reg <= {quo_reg[DIVD_W-2:0], ~diff[DIVS_W]};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

>>> rtl/srpr_ctrl.sv
// Controller state machine that sequences each beat through the datapath.
`default_nettype none
module srpr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire srpr_pkg::status_t st,
    output srpr_pkg::cmd_t         cmd,
    output logic                   s_tready
);
    import srpr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_CFG_WAIT, S_CFG_APPLY, S_START_WAIT, S_START_APPLY,
        S_PULSE, S_LERP_MUL, S_LERP_DIV, S_LERP_WAIT, S_LERP_APPLY, S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Command and next state from the current state and datapath status.
    always_comb begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (st.cfg_pending) begin
                    cmd        = CMD_CFG_TAKE;
                    state_next = st.cruise_zero ? S_IDLE : S_CFG_WAIT;
                end else if (st.in_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd = CMD_DISPATCH;
                if (!st.in_start) begin
                    state_next = S_PULSE;
                end else begin
                    state_next = st.start_need_div ? S_START_WAIT : S_START_APPLY;
                end
            end
            S_CFG_WAIT:    if (st.div_done) state_next = S_CFG_APPLY;
            S_CFG_APPLY: begin
                cmd        = CMD_CFG_APPLY;
                state_next = S_IDLE;
            end
            S_START_WAIT:  if (st.div_done) state_next = S_START_APPLY;
            S_START_APPLY: begin
                cmd        = CMD_START_APPLY;
                state_next = S_EMIT;
            end
            S_PULSE: begin
                cmd        = CMD_PULSE;
                state_next = st.pulse_lerp ? S_LERP_MUL : S_EMIT;
            end
            S_LERP_MUL: begin
                cmd        = CMD_LERP_MUL;
                state_next = S_LERP_DIV;
            end
            S_LERP_DIV: begin
                cmd        = CMD_DIV_LERP;
                state_next = S_LERP_WAIT;
            end
            S_LERP_WAIT:   if (st.div_done) state_next = S_LERP_APPLY;
            S_LERP_APPLY: begin
                cmd        = CMD_LERP_APPLY;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !st.cfg_pending;
endmodule
`default_nettype wire

>>> rtl/srpr_dp.sv
// Datapath: move state, register file, interpolation and the output register.
`default_nettype none
module srpr_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire srpr_pkg::cmd_t                  cmd,
    output srpr_pkg::status_t                    st,
    input  wire logic                            s_tvalid,
    input  wire logic [srpr_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            cfg_wr,
    input  wire logic [srpr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [srpr_pkg::M_DATA_W-1:0]        m_tdata
);
    import srpr_pkg::*;

    logic [RATE_W-1:0]   cruise_rate_reg;
    logic                cfg_pending_reg;
    logic [COUNT_W-1:0]  remaining_reg;
    logic [PERIOD_W-1:0] start_period_reg;
    logic [PERIOD_W-1:0] cruise_period_reg;
    logic [RAMP_W-1:0]   up_total_reg;
    logic [RAMP_W-1:0]   up_left_reg;
    logic [RAMP_W-1:0]   down_total_reg;
    logic [PERIOD_W-1:0] current_reg;
    logic                running_reg;
    logic                done_flag_reg;
    logic                in_op_reg;
    logic [COUNT_W-1:0]  in_steps_reg;
    logic [COUNT_W-1:0]  in_ramp_reg;
    logic [RATE_W-1:0]   in_rate_reg;
    logic [PERIOD_W-1:0] from_reg;
    logic [PERIOD_W-1:0] to_reg;
    logic [RAMP_W-1:0]   ldone_reg;
    logic [RAMP_W-1:0]   ltotal_reg;
    logic                lsame_reg;
    logic [DIVD_W-1:0]   prod_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic                div_start;
    logic [DIVD_W-1:0]   div_dividend;
    logic [DIVS_W-1:0]   div_divisor;
    logic                div_done;
    logic [DIVD_W-1:0]   div_quot;

    logic [COUNT_W-1:0]  rem_new;
    logic                pulse_finish;
    logic                pulse_up;
    logic                pulse_down;
    logic                down_last;
    logic                need_div;
    logic [PERIOD_W-1:0] sp_new;
    logic [COUNT_W-1:0]  half_steps;
    logic [RAMP_W-1:0]   ramp_each;
    logic                use_ramp;
    logic [PERIOD_W-1:0] span;
    logic [PERIOD_W-1:0] lerp_out;
    logic [PERIOD_W:0]   high_calc;

    // Pulse decision from the state before the update.
    always_comb begin
        rem_new      = (remaining_reg != '0) ? remaining_reg - COUNT_W'(1) : remaining_reg;
        pulse_finish = (rem_new == '0);
        pulse_up     = !pulse_finish && (up_left_reg != '0);
        pulse_down   = !pulse_finish && (up_left_reg == '0) && (down_total_reg != '0)
                       && (rem_new <= COUNT_W'(down_total_reg));
        down_last    = pulse_down && (rem_new == COUNT_W'(1));
    end

    // Start-move helpers.
    always_comb begin
        need_div   = (in_ramp_reg != '0) && (in_rate_reg != '0);
        sp_new     = need_div ? period_from_quot(div_quot) : '0;
        half_steps = in_steps_reg >> 1;
        ramp_each  = (in_ramp_reg < half_steps) ? in_ramp_reg[RAMP_W-1:0]
                                                : half_steps[RAMP_W-1:0];
        use_ramp   = (in_ramp_reg != '0) && (in_steps_reg != '0)
                     && (sp_new > cruise_period_reg);
    end

    // Interpolation step: span times progress, then the divider, then the offset.
    always_comb begin
        span      = (from_reg > to_reg) ? from_reg - to_reg : to_reg - from_reg;
        lerp_out  = (from_reg > to_reg) ? from_reg - div_quot[PERIOD_W-1:0]
                                        : from_reg + div_quot[PERIOD_W-1:0];
        high_calc = ({1'b0, current_reg} + 17'd1) >> 1;
    end

    // Divider operand selection.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = TICK_HZ;
        div_divisor  = DIVS_W'(cruise_rate_reg);
        unique case (cmd)
            CMD_CFG_TAKE: div_start = (cruise_rate_reg != '0);
            CMD_DISPATCH: begin
                div_start   = (in_op_reg == OP_START) && need_div;
                div_divisor = DIVS_W'(in_rate_reg);
            end
            CMD_DIV_LERP: begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = ltotal_reg;
            end
            default: div_start = 1'b0;
        endcase
    end

    srpr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Move and configuration state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cruise_rate_reg   <= RESET_RATE;
            cfg_pending_reg   <= 1'b0;
            remaining_reg     <= '0;
            start_period_reg  <= '0;
            cruise_period_reg <= RESET_PERIOD;
            up_total_reg      <= '0;
            up_left_reg       <= '0;
            down_total_reg    <= '0;
            current_reg       <= RESET_PERIOD;
            running_reg       <= 1'b0;
            done_flag_reg     <= 1'b1;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[ADDR_W-1] == 1'b0)) begin
                cruise_rate_reg <= pwdata[RATE_W-1:0];
                cfg_pending_reg <= 1'b1;
            end else if (cmd == CMD_CFG_TAKE) begin
                cfg_pending_reg <= 1'b0;
            end
            if (cmd == CMD_EMIT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (cmd)
                CMD_CFG_TAKE: begin
                    if (cruise_rate_reg == '0) begin
                        running_reg <= 1'b0;
                    end
                end
                CMD_CFG_APPLY: begin
                    cruise_period_reg <= period_from_quot(div_quot);
                    if (up_left_reg == '0) begin
                        current_reg <= period_from_quot(div_quot);
                    end
                end
                CMD_LOAD: begin
                    in_op_reg    <= s_tuser;
                    in_steps_reg <= s_tdata[COUNT_W-1:0];
                    in_ramp_reg  <= s_tdata[2*COUNT_W-1:COUNT_W];
                    in_rate_reg  <= s_tdata[2*COUNT_W+RATE_W-1:2*COUNT_W];
                end
                CMD_START_APPLY: begin
                    remaining_reg    <= in_steps_reg;
                    start_period_reg <= sp_new;
                    if (use_ramp) begin
                        up_total_reg   <= ramp_each;
                        up_left_reg    <= ramp_each;
                        down_total_reg <= ramp_each;
                        current_reg    <= (ramp_each != '0) ? sp_new : cruise_period_reg;
                    end else begin
                        up_left_reg    <= '0;
                        down_total_reg <= '0;
                        current_reg    <= cruise_period_reg;
                    end
                    running_reg <= (in_steps_reg != '0);
                    if (in_steps_reg != '0) begin
                        done_flag_reg <= 1'b0;
                    end
                end
                CMD_PULSE: begin
                    if (running_reg) begin
                        remaining_reg <= rem_new;
                        if (pulse_finish) begin
                            done_flag_reg <= 1'b1;
                            running_reg   <= 1'b0;
                        end else if (pulse_up) begin
                            up_left_reg <= up_left_reg - RAMP_W'(1);
                            from_reg    <= start_period_reg;
                            to_reg      <= cruise_period_reg;
                            ldone_reg   <= up_total_reg - up_left_reg + RAMP_W'(1);
                            ltotal_reg  <= up_total_reg;
                            lsame_reg   <= (start_period_reg == cruise_period_reg);
                        end else if (down_last) begin
                            current_reg <= start_period_reg;
                        end else if (pulse_down) begin
                            from_reg   <= cruise_period_reg;
                            to_reg     <= start_period_reg;
                            ldone_reg  <= down_total_reg - rem_new[RAMP_W-1:0];
                            ltotal_reg <= down_total_reg;
                            lsame_reg  <= (start_period_reg == cruise_period_reg);
                        end
                    end
                end
                CMD_LERP_MUL: begin
                    prod_reg <= DIVD_W'(span) * DIVD_W'(ldone_reg);
                end
                CMD_LERP_APPLY: begin
                    current_reg <= lsame_reg ? to_reg : lerp_out;
                end
                CMD_EMIT: begin
                    m_tdata_reg  <= {6'd0, done_flag_reg, running_reg,
                                     high_calc[PERIOD_W-1:0], current_reg};
                end
                default: begin
                end
            endcase
        end
    end

    // Status toward the controller.
    always_comb begin
        st.cfg_pending    = cfg_pending_reg;
        st.cruise_zero    = (cruise_rate_reg == '0);
        st.in_valid       = s_tvalid;
        st.in_start       = (in_op_reg == OP_START);
        st.start_need_div = need_div;
        st.pulse_lerp     = running_reg && !down_last && (pulse_up || pulse_down);
        st.div_done       = div_done;
        st.out_free       = !m_tvalid_reg || m_tready;
    end

    assign prdata   = (paddr[ADDR_W-1] == 1'b0) ? 32'(cruise_rate_reg) : 32'd0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule
`default_nettype wire

>>> rtl/stepper_ramp_pulse_rate.sv
// Trapezoidal stepper pulse-period generator, top level.
// A pulse beat goes through dispatch, pulse and emit; when it interpolates it also goes
// through multiply, divide and apply. A start beat goes through dispatch, start apply and
// emit, after a divide when it derives the start period. One beat is in work at a time and
// the next can be taken the cycle after the result is issued, unless a cruise_rate write is
// pending; such a write holds off input beats while it is handled. Reset restores cruise_rate 500.
`default_nettype none
`include "stepper_ramp_pulse_rate_assert.svh"
module stepper_ramp_pulse_rate (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: move_steps[23:0], ramp_steps[47:24], start_rate[67:48], zero pad
    input  wire logic [srpr_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: opcode
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: period_wrap[15:0], high_level[31:16], run_enable[32],
    // move_finished[33], zero pad
    output logic [srpr_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [srpr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import srpr_pkg::*;

    cmd_t    cmd;
    status_t st;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    srpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .st       (st),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    srpr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_wr   (cfg_wr),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A running move is never reported as finished.
    `SRPR_ASSERT_IMP(a_run_not_done, aclk, aresetn, m_tvalid,
                     !(m_tdata[32] && m_tdata[33]), "run and finished both set")
    // The high time is half the period, rounded up.
    `SRPR_ASSERT_IMP(a_half_duty, aclk, aresetn, m_tvalid,
                     ({1'b0, m_tdata[31:16]} == (({1'b0, m_tdata[15:0]} + 17'd1) >> 1)),
                     "high level mismatch")
    // After an input beat the block is busy with it.
    `SRPR_ASSERT_NXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready,
                     "ready right after a beat")
endmodule
`default_nettype wire
